// ===== sv/lz_bitstream_section_decompressor_top_assert.svh =====
// Assertion macros shared by the decompressor modules.
`ifndef LZ_BITSTREAM_SECTION_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ_BITSTREAM_SECTION_DECOMPRESSOR_TOP_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define LZSD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by reset.
`define LZSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lzsd_pkg.sv =====
`timescale 1ns / 1ps
package lzsd_pkg;

	localparam int HISTORY_BITS_DEF = 16;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int CAP_BYTES = 256;
	localparam int CARRY_MAX = 16;
	localparam int CARRY_W = $clog2(CARRY_MAX);

	localparam logic [7:0] SIG_F = 8'h46;
	localparam logic [7:0] SIG_A = 8'h41;
	localparam logic [7:0] SIG_B = 8'h42;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_HDR    = 3'd1;
	localparam logic [2:0] ST_TRUNC  = 3'd2;
	localparam logic [2:0] ST_OVF    = 3'd3;
	localparam logic [2:0] ST_BEFORE = 3'd4;
	localparam logic [2:0] ST_SIZE   = 3'd5;
	localparam logic [2:0] ST_WINDOW = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [2:0] out_count;
		logic       run_last;
		logic       finished;
		logic [2:0] status;
	} out_word_t;

	// classified source byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_zero;
		logic       is_one;
		logic       shift_ok;
	} item_t;

	typedef enum logic [3:0] {
		PH_SIG0   = 4'd0,
		PH_SIG1   = 4'd1,
		PH_SIG2   = 4'd2,
		PH_SHIFT  = 4'd3,
		PH_CW_LO  = 4'd4,
		PH_CW_HI  = 4'd5,
		PH_BITS   = 4'd6,
		PH_REF_LO = 4'd7,
		PH_REF_HI = 4'd8,
		PH_LIT    = 4'd9,
		PH_SOFS   = 4'd10,
		PH_LONG0  = 4'd11,
		PH_LONG1  = 4'd12,
		PH_EXTRA  = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		BS_CMD  = 2'd0,
		BS_KIND = 2'd1,
		BS_LA   = 2'd2,
		BS_LB   = 2'd3
	} bstage_t;

endpackage

// ===== sv/lz_bitstream_section_decompressor_top.sv =====
`timescale 1ns / 1ps
// Each source word is popped from the queue and its carried bytes are emitted; it is then fed,
//   its control bits are walked in S_BITS, and any copy runs before the flush.
// Flow per item: pop, feed, phase check, flush; no new item is taken until the back end is idle.
//   Copies use the history RAM for each byte as a registered read, then a write.
// Results leave through a one-entry output register; a 4-entry input queue decouples the source.
// Reset: arst_n async low clears control, parser phase and counters; history RAM is not cleared.
module lz_bitstream_section_decompressor_top #(
	parameter int HISTORY_BITS = lzsd_pkg::HISTORY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [23:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  lzsd_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lzsd_pkg::out_word_t out_data
);
	logic            q_valid, q_pop;
	lzsd_pkg::item_t q_item;

	// front: classify each source word and queue it
	lzsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// back: header/bit parsing, copy engine, history RAM, output packing
	lzsd_back #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);
endmodule

// ===== sv/lzsd_front.sv =====
`timescale 1ns / 1ps
`include "lz_bitstream_section_decompressor_top_assert.svh"
module lzsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lzsd_pkg::in_word_t in_data,
	output logic               q_valid,
	input  logic               q_pop,
	output lzsd_pkg::item_t    q_item
);
	lzsd_pkg::item_t mem_q [lzsd_pkg::QDEPTH];
	logic [lzsd_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [lzsd_pkg::QPTR_W:0]   cnt_q;
	lzsd_pkg::item_t cls;
	logic push;

	always_comb begin
		cls.data     = in_data.in_byte;
		cls.last     = in_data.last_byte;
		cls.is_zero  = in_data.in_byte == 8'd0;
		cls.is_one   = in_data.in_byte == 8'd1;
		cls.shift_ok = in_data.in_byte inside {[8'd8:8'd16]};
	end

	assign in_ready = cnt_q != (lzsd_pkg::QPTR_W+1)'(lzsd_pkg::QDEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != '0;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`LZSD_ASSERT(a_pop_nonempty, q_pop, cnt_q != '0, "pop from empty queue")
	`LZSD_ASSERT_NXT(a_push_count, push && !q_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count slip")
	`LZSD_ASSERT(a_full_stall, cnt_q == (lzsd_pkg::QPTR_W+1)'(lzsd_pkg::QDEPTH), !in_ready, "ready while full")
endmodule

// ===== sv/lzsd_back.sv =====
`timescale 1ns / 1ps
`include "lz_bitstream_section_decompressor_top_assert.svh"
module lzsd_back #(
	parameter int HISTORY_BITS = lzsd_pkg::HISTORY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [23:0]         cfg_wr_data,
	input  logic                q_valid,
	output logic                q_pop,
	input  lzsd_pkg::item_t     q_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lzsd_pkg::out_word_t out_data
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CARRY = 7'b0000010,
		S_FEED  = 7'b0000100,
		S_CP_RD = 7'b0001000,
		S_CP_WR = 7'b0010000,
		S_BITS  = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	localparam logic [24:0] HSIZE = 25'd1 << HISTORY_BITS;

	state_t st_q, st_d;
	lzsd_pkg::item_t itm_q, itm_d;
	lzsd_pkg::phase_t ph_q, ph_d;
	lzsd_pkg::bstage_t bst_q, bst_d;
	logic [16:0] bitbuf_q, bitbuf_d;
	logic [4:0]  brem_q, brem_d;
	logic [23:0] pc_q, pc_d, exp_q;
	logic [4:0]  shift_q, shift_d;
	logic [7:0]  plow_q, plow_d;
	logic [8:0]  plen_q, plen_d;
	logic [16:0] pdist_q, pdist_d;
	logic        ended_q, ended_d, end_now_q, end_now_d;
	logic [2:0]  end_st_q, end_st_d;
	logic [lzsd_pkg::CARRY_W-1:0] crd_q, crd_d;
	logic [8:0]  cpn_q, cpn_d;
	logic [16:0] cpd_q, cpd_d;

	// packer / carry
	logic [7:0] grp_q [4];
	logic [2:0] grp_n_q;
	logic [8:0] stp_q;
	logic [lzsd_pkg::CARRY_W:0] cn_q;
	logic [7:0] carry_q [lzsd_pkg::CARRY_MAX];
	logic       ov_q;
	lzsd_pkg::out_word_t out_q;

	logic [7:0] hist_q [2**HISTORY_BITS];
	logic [7:0] hrd_q;
	logic       hist_re, hist_we;
	logic [HISTORY_BITS-1:0] raddr;

	logic push_req, push_ok, push_go, out_free, flush_go, over_cap;
	logic [7:0] push_byte;
	logic fin, cp_start, bit_v, ovf;
	logic [2:0] fin_st;
	logic [8:0] cp_len;
	logic [16:0] cp_dist;
	logic carry_done;

	// long copy field split
	logic [3:0]  cs;
	logic [7:0]  fill, lmask, ohi, lg_len;
	logic [16:0] lg_dist;

	always_comb begin
		cs      = 4'(5'd16 - shift_q);
		fill    = 8'(16'h00FF << (shift_q - 5'd8));
		lmask   = 8'((16'd1 << cs) - 16'd1);
		ohi     = 8'({8'd0, itm_q.data} >> cs) | fill;
		lg_len  = itm_q.data & lmask;
		lg_dist = 17'h10000 - {1'b0, ohi, plow_q};
	end

	assign ovf      = pc_q >= exp_q;
	assign out_free = !ov_q || out_ready;
	assign over_cap = stp_q >= 9'(lzsd_pkg::CAP_BYTES);
	assign push_ok  = over_cap || grp_n_q != 3'd4 || out_free;
	assign push_go  = push_req && push_ok;
	assign flush_go = st_q == S_FLUSH && (grp_n_q != 3'd0 || end_now_q) && out_free;
	assign q_pop    = st_q == S_IDLE && q_valid;
	assign carry_done = (5'(crd_q) + 5'd1) == 5'(cn_q);
	assign bit_v    = bitbuf_q[0];
	assign raddr    = HISTORY_BITS'(pc_q - 24'(cpd_q));
	assign hist_we  = push_go && (st_q == S_CP_WR || st_q == S_FEED);

	always_comb begin
		push_req  = 1'b0;
		push_byte = '0;
		case (st_q)
			S_CARRY: begin
				push_req  = 1'b1;
				push_byte = carry_q[crd_q];
			end
			S_FEED: begin
				if (ph_q == lzsd_pkg::PH_LIT && !ovf) begin
					push_req  = 1'b1;
					push_byte = itm_q.data;
				end
			end
			S_CP_WR: begin
				push_req  = 1'b1;
				push_byte = hrd_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q; itm_d = itm_q; ph_d = ph_q; bst_d = bst_q;
		bitbuf_d = bitbuf_q; brem_d = brem_q; pc_d = pc_q; shift_d = shift_q;
		plow_d = plow_q; plen_d = plen_q; pdist_d = pdist_q;
		ended_d = ended_q; end_now_d = end_now_q; end_st_d = end_st_q;
		crd_d = crd_q; cpn_d = cpn_q; cpd_d = cpd_q;
		fin = 1'b0; fin_st = lzsd_pkg::ST_OK; hist_re = 1'b0;
		cp_start = 1'b0; cp_len = '0; cp_dist = '0;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					itm_d     = q_item;
					end_now_d = 1'b0;
					end_st_d  = lzsd_pkg::ST_OK;
					crd_d     = '0;
					if (!ended_q) begin
						st_d = (cn_q != '0) ? S_CARRY : S_FEED;
					end
				end
			end
			S_CARRY: begin
				if (push_ok) begin
					crd_d = crd_q + 1'b1;
					if (carry_done) begin
						st_d = S_FEED;
					end
				end
			end
			S_FEED: begin
				st_d = S_BITS;
				case (ph_q)
					lzsd_pkg::PH_SIG0: begin
						if (itm_q.data == lzsd_pkg::SIG_F) ph_d = lzsd_pkg::PH_SIG1;
						else begin fin = 1'b1; fin_st = lzsd_pkg::ST_HDR; end
					end
					lzsd_pkg::PH_SIG1: begin
						if (itm_q.data == lzsd_pkg::SIG_A) ph_d = lzsd_pkg::PH_SIG2;
						else begin fin = 1'b1; fin_st = lzsd_pkg::ST_HDR; end
					end
					lzsd_pkg::PH_SIG2: begin
						if (itm_q.data == lzsd_pkg::SIG_B) ph_d = lzsd_pkg::PH_SHIFT;
						else begin fin = 1'b1; fin_st = lzsd_pkg::ST_HDR; end
					end
					lzsd_pkg::PH_SHIFT: begin
						if (!itm_q.shift_ok) begin
							fin = 1'b1; fin_st = lzsd_pkg::ST_HDR;
						end else begin
							shift_d = itm_q.data[4:0];
							ph_d    = lzsd_pkg::PH_CW_LO;
						end
					end
					lzsd_pkg::PH_CW_LO: begin
						plow_d = itm_q.data;
						ph_d   = lzsd_pkg::PH_CW_HI;
					end
					lzsd_pkg::PH_CW_HI: begin
						bitbuf_d = {1'b0, itm_q.data, plow_q};
						brem_d   = 5'd16;
						ph_d     = lzsd_pkg::PH_BITS;
						bst_d    = lzsd_pkg::BS_CMD;
					end
					lzsd_pkg::PH_REF_LO: begin
						plow_d = itm_q.data;
						ph_d   = lzsd_pkg::PH_REF_HI;
					end
					lzsd_pkg::PH_REF_HI: begin
						// leftover bit stays at the bottom; 17 bits to walk
						bitbuf_d = {itm_q.data, plow_q, bitbuf_q[0]};
						brem_d   = 5'd17;
						ph_d     = lzsd_pkg::PH_BITS;
					end
					lzsd_pkg::PH_LIT: begin
						if (ovf) begin
							fin = 1'b1; fin_st = lzsd_pkg::ST_OVF;
						end else if (push_ok) begin
							pc_d  = pc_q + 24'd1;
							ph_d  = lzsd_pkg::PH_BITS;
							bst_d = lzsd_pkg::BS_CMD;
						end else begin
							st_d = S_FEED;
						end
					end
					lzsd_pkg::PH_SOFS: begin
						cp_start = 1'b1;
						cp_len   = plen_q;
						cp_dist  = 17'(9'd256 - {1'b0, itm_q.data});
					end
					lzsd_pkg::PH_LONG0: begin
						plow_d = itm_q.data;
						ph_d   = lzsd_pkg::PH_LONG1;
					end
					lzsd_pkg::PH_LONG1: begin
						if (lg_len == 8'd0) begin
							pdist_d = lg_dist;
							ph_d    = lzsd_pkg::PH_EXTRA;
						end else begin
							cp_start = 1'b1;
							cp_len   = 9'(lg_len) + 9'd2;
							cp_dist  = lg_dist;
						end
					end
					lzsd_pkg::PH_EXTRA: begin
						if (itm_q.is_zero) begin
							fin    = 1'b1;
							fin_st = (pc_q == exp_q) ? lzsd_pkg::ST_OK : lzsd_pkg::ST_SIZE;
						end else if (itm_q.is_one) begin
							ph_d  = lzsd_pkg::PH_BITS;
							bst_d = lzsd_pkg::BS_CMD;
						end else begin
							cp_start = 1'b1;
							cp_len   = 9'(itm_q.data) + 9'd1;
							cp_dist  = pdist_q;
						end
					end
					default: ;
				endcase
				// last byte inside the header
				if (!fin && itm_q.last && ph_d <= lzsd_pkg::PH_CW_HI) begin
					fin = 1'b1; fin_st = lzsd_pkg::ST_HDR;
				end
				if (cp_start) begin
					cpn_d = cp_len;
					cpd_d = cp_dist;
					st_d  = S_CP_RD;
				end
			end
			S_CP_RD: begin
				st_d = S_BITS;
				if (cpn_q == 9'd0) begin
					ph_d  = lzsd_pkg::PH_BITS;
					bst_d = lzsd_pkg::BS_CMD;
				end else if (ovf) begin
					fin = 1'b1; fin_st = lzsd_pkg::ST_OVF;
				end else if (24'(cpd_q) > pc_q) begin
					fin = 1'b1; fin_st = lzsd_pkg::ST_BEFORE;
				end else if (25'(cpd_q) > HSIZE) begin
					fin = 1'b1; fin_st = lzsd_pkg::ST_WINDOW;
				end else begin
					hist_re = 1'b1;
					st_d    = S_CP_WR;
				end
			end
			S_CP_WR: begin
				if (push_ok) begin
					pc_d  = pc_q + 24'd1;
					cpn_d = cpn_q - 9'd1;
					st_d  = S_CP_RD;
				end
			end
			S_BITS: begin
				if (ended_q) begin
					st_d = S_FLUSH;
				end else if (ph_q != lzsd_pkg::PH_BITS) begin
					if (itm_q.last && ph_q >= lzsd_pkg::PH_BITS) begin
						fin = 1'b1; fin_st = lzsd_pkg::ST_TRUNC;
					end
					st_d = S_FLUSH;
				end else if (brem_q <= 5'd1) begin
					ph_d = lzsd_pkg::PH_REF_LO;
				end else begin
					brem_d   = brem_q - 5'd1;
					bitbuf_d = {1'b0, bitbuf_q[16:1]};
					case (bst_q)
						lzsd_pkg::BS_CMD: begin
							if (bit_v) begin
								if (itm_q.last) begin
									fin = 1'b1; fin_st = lzsd_pkg::ST_TRUNC;
								end else if (ovf) begin
									fin = 1'b1; fin_st = lzsd_pkg::ST_OVF;
								end else begin
									ph_d = lzsd_pkg::PH_LIT;
								end
							end else begin
								bst_d = lzsd_pkg::BS_KIND;
							end
						end
						lzsd_pkg::BS_KIND: begin
							if (bit_v) begin
								ph_d = lzsd_pkg::PH_LONG0;
							end else begin
								plen_d = '0;
								bst_d  = lzsd_pkg::BS_LA;
							end
						end
						lzsd_pkg::BS_LA: begin
							plen_d = 9'(bit_v);
							bst_d  = lzsd_pkg::BS_LB;
						end
						default: begin
							plen_d = 9'({plen_q[0], bit_v}) + 9'd2;
							ph_d   = lzsd_pkg::PH_SOFS;
						end
					endcase
				end
			end
			S_FLUSH: begin
				if ((grp_n_q == 3'd0 && !end_now_q) || out_free) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
		if (fin) begin
			ended_d   = 1'b1;
			end_now_d = 1'b1;
			end_st_d  = fin_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; itm_q <= '0; ph_q <= lzsd_pkg::PH_SIG0; bst_q <= lzsd_pkg::BS_CMD;
			bitbuf_q <= '0; brem_q <= 5'd16; pc_q <= '0; shift_q <= '0;
			plow_q <= '0; plen_q <= '0; pdist_q <= '0;
			ended_q <= 1'b0; end_now_q <= 1'b0; end_st_q <= lzsd_pkg::ST_OK;
			crd_q <= '0; cpn_q <= '0; cpd_q <= '0; exp_q <= '0;
		end else begin
			st_q <= st_d; itm_q <= itm_d; ph_q <= ph_d; bst_q <= bst_d;
			bitbuf_q <= bitbuf_d; brem_q <= brem_d; pc_q <= pc_d; shift_q <= shift_d;
			plow_q <= plow_d; plen_q <= plen_d; pdist_q <= pdist_d;
			ended_q <= ended_d; end_now_q <= end_now_d; end_st_q <= end_st_d;
			crd_q <= crd_d; cpn_q <= cpn_d; cpd_q <= cpd_d;
			if (cfg_wr_en) begin
				exp_q <= cfg_wr_data;
			end
		end
	end

	// history RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_q[pc_q[HISTORY_BITS-1:0]] <= push_byte;
		end
		if (hist_re) begin
			hrd_q <= hist_q[raddr];
		end
	end

	// byte packer; bytes past the per-word cap wait in the carry buffer
	always_ff @(posedge clk) begin
		if (push_go && over_cap) begin
			carry_q[stp_q[lzsd_pkg::CARRY_W-1:0]] <= push_byte;
		end
		if (push_go && !over_cap && grp_n_q == 3'd4) begin
			out_q <= '{grp_q[0], grp_q[1], grp_q[2], grp_q[3], 3'd4, 1'b0, 1'b0,
				lzsd_pkg::ST_OK};
		end else if (flush_go) begin
			out_q <= '{grp_q[0], grp_q[1], grp_q[2], grp_q[3], grp_n_q, 1'b1,
				end_now_q, end_st_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			grp_n_q <= '0;
			stp_q   <= '0;
			cn_q    <= '0;
			for (int i = 0; i < 4; i++) grp_q[i] <= '0;
		end else begin
			if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (st_q == S_IDLE) begin
				stp_q <= '0;
			end
			if (push_go) begin
				stp_q <= stp_q + 9'd1;
				if (over_cap) begin
					cn_q <= (lzsd_pkg::CARRY_W+1)'(stp_q - 9'(lzsd_pkg::CAP_BYTES - 1));
				end else if (grp_n_q == 3'd4) begin
					ov_q     <= 1'b1;
					grp_q[0] <= push_byte;
					grp_q[1] <= '0;
					grp_q[2] <= '0;
					grp_q[3] <= '0;
					grp_n_q  <= 3'd1;
				end else begin
					grp_q[grp_n_q[1:0]] <= push_byte;
					grp_n_q <= grp_n_q + 3'd1;
				end
				if (st_q == S_CARRY && carry_done) begin
					cn_q <= '0;
				end
			end
			if (flush_go) begin
				ov_q    <= 1'b1;
				grp_n_q <= '0;
				for (int i = 0; i < 4; i++) grp_q[i] <= '0;
				if (end_now_q) begin
					cn_q <= '0;
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

	`LZSD_ASSERT(a_fin_last, ov_q && out_q.finished, out_q.run_last, "finished word without run_last")
	`LZSD_ASSERT(a_cnt_ok, ov_q, out_q.out_count <= 3'd4 && (out_q.out_count != 3'd0 || out_q.finished), "bad out_count")
	`LZSD_ASSERT_NXT(a_ended_sticks, ended_q, ended_q, "ended flag dropped")
endmodule
